### hdl/tbsli_pkg.sv
// Shared constants and types for the table binary search interpolator.
package tbsli_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int VAL_W       = 32;
    localparam int FRAC_W      = 16;
    localparam int FRAC_FULL_W = FRAC_W + 1;
    localparam int STEP_W      = $clog2(FRAC_W);

    localparam logic [FRAC_FULL_W-1:0] FRAC_ONE  = FRAC_FULL_W'(1) << FRAC_W;
    localparam logic [FRAC_FULL_W-1:0] FRAC_ZERO = '0;

    localparam logic [1:0] STATUS_INSIDE = 2'd0;
    localparam logic [1:0] STATUS_BELOW  = 2'd1;
    localparam logic [1:0] STATUS_ABOVE  = 2'd2;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Start request to the serial divider: dividend is below divisor.
    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] dividend;
        logic [VAL_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [FRAC_W-1:0] quotient;
    } div_rsp_t;

endpackage

### hdl/tbsli_mem.sv
// Point table: x and y memories with one write port and one registered read port.
module tbsli_mem
    import tbsli_pkg::*;
(
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [IDX_W-1:0]        wr_addr,
    input  logic signed [VAL_W-1:0] wr_x,
    input  logic signed [VAL_W-1:0] wr_y,
    input  logic [IDX_W-1:0]        rd_addr,
    output logic signed [VAL_W-1:0] rd_x,
    output logic signed [VAL_W-1:0] rd_y
);

    logic signed [VAL_W-1:0] x_mem [TABLE_DEPTH];
    logic signed [VAL_W-1:0] y_mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            x_mem[wr_addr] <= wr_x;
            y_mem[wr_addr] <= wr_y;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_x <= x_mem[rd_addr];
        rd_y <= y_mem[rd_addr];
    end

endmodule

### hdl/tbsli_div.sv
// Restoring serial divider: one quotient bit of a proper fraction per cycle.
module tbsli_div
    import tbsli_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [VAL_W-1:0]  rem_reg;
    logic [VAL_W-1:0]  dsr_reg;
    logic [FRAC_W-1:0] quo_reg;

    logic [VAL_W:0]    shifted;
    logic [VAL_W:0]    diff;
    logic              ge;
    logic [VAL_W-1:0]  rem_next;

    // Remainder stays below the divisor, so the shifted value fits one extra bit.
    assign shifted  = {rem_reg, 1'b0};
    assign diff     = shifted - {1'b0, dsr_reg};
    assign ge       = shifted >= {1'b0, dsr_reg};
    assign rem_next = ge ? diff[VAL_W-1:0] : shifted[VAL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(FRAC_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.dividend;
            dsr_reg <= req.divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[FRAC_W-2:0], ge};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### hdl/table_binary_search_linear_interp.sv
// Top level: request sequencer, binary search, fraction and interpolation datapath.
// Queries below or above the table are answered from the end points; inside, a query
// takes s <= ceil(log2(n-1)) search steps and, for a fraction strictly between 0 and 1,
// the 16-step serial divider. A write request leaves the input ready for the next request.
// The input reopens as the result is registered; a result waits while that register is full.
// rst_n clears control state and sets points_in_use to 2; table contents are undefined.
module table_binary_search_linear_interp
    import tbsli_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [8:0]    cfg_wdata,     // points_in_use
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [103:0]  s_axis_tdata,  // entry_index, entry_x, entry_y, query_x
    input  logic          s_axis_tuser,  // kind
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [63:0]   m_axis_tdata   // status, lower_index, fraction, interpolated
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_FIRST = 11'b00000000010,
        S_LAST  = 11'b00000000100,
        S_CLASS = 11'b00000001000,
        S_PROBE = 11'b00000010000,
        S_CMP   = 11'b00000100000,
        S_FRAC  = 11'b00001000000,
        S_DIV   = 11'b00010000000,
        S_MUL   = 11'b00100000000,
        S_ADD   = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    localparam int OUT_W = 2 + IDX_W + FRAC_FULL_W + VAL_W;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         points_reg;
    logic [IDX_W-1:0]         last_reg, last_next;
    logic [IDX_W-1:0]         lo_reg, lo_next;
    logic [IDX_W-1:0]         hi_reg, hi_next;
    logic signed [VAL_W-1:0]  q_reg, q_next;
    logic signed [VAL_W-1:0]  x_lo_reg, x_lo_next;
    logic signed [VAL_W-1:0]  x_hi_reg, x_hi_next;
    logic signed [VAL_W-1:0]  y_lo_reg, y_lo_next;
    logic signed [VAL_W-1:0]  y_hi_reg, y_hi_next;
    logic [1:0]               status_reg, status_next;
    logic [FRAC_FULL_W-1:0]   frac_reg, frac_next;
    logic signed [VAL_W-1:0]  interp_reg, interp_next;
    logic signed [50:0]       prod_reg, prod_next;
    logic                     m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]         m_data_reg, m_data_next;

    logic                     accept;
    logic                     in_kind;
    logic [IDX_W-1:0]         in_index;
    logic signed [VAL_W-1:0]  in_x, in_y, in_q;

    logic [IDX_W-1:0]         rd_addr;
    logic signed [VAL_W-1:0]  rd_x, rd_y;
    logic [IDX_W:0]           mid_sum;
    logic [IDX_W-1:0]         mid;
    logic [IDX_W-1:0]         gap_next;

    logic signed [VAL_W:0]    a_diff, span, dy;
    logic [VAL_W:0]           a_mag, s_mag;
    div_req_t                 div_req;
    div_rsp_t                 div_rsp;
    logic                     out_free;

    assign in_kind  = s_axis_tuser;
    assign in_index = s_axis_tdata[7:0];
    assign in_x     = s_axis_tdata[39:8];
    assign in_y     = s_axis_tdata[71:40];
    assign in_q     = s_axis_tdata[103:72];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[IDX_W:1];
    assign gap_next = hi_next - lo_next;

    assign a_diff = {q_reg[VAL_W-1], q_reg} - {x_lo_reg[VAL_W-1], x_lo_reg};
    assign span   = {x_hi_reg[VAL_W-1], x_hi_reg} - {x_lo_reg[VAL_W-1], x_lo_reg};
    assign dy     = {y_hi_reg[VAL_W-1], y_hi_reg} - {y_lo_reg[VAL_W-1], y_lo_reg};
    assign a_mag  = a_diff[VAL_W] ? (VAL_W+1)'(0) - a_diff : a_diff;
    assign s_mag  = span[VAL_W] ? (VAL_W+1)'(0) - span : span;

    tbsli_mem u_mem (
        .clk     (clk),
        .wr_en   (accept && (in_kind == KIND_WRITE)),
        .wr_addr (in_index),
        .wr_x    (in_x),
        .wr_y    (in_y),
        .rd_addr (rd_addr),
        .rd_x    (rd_x),
        .rd_y    (rd_y)
    );

    tbsli_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        case (state_reg)
            S_LAST:  rd_addr = last_reg;
            S_PROBE: rd_addr = mid;
            default: rd_addr = '0;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        last_next    = last_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        q_next       = q_reg;
        x_lo_next    = x_lo_reg;
        x_hi_next    = x_hi_reg;
        y_lo_next    = y_lo_reg;
        y_hi_next    = y_hi_reg;
        status_next  = status_reg;
        frac_next    = frac_reg;
        interp_next  = interp_reg;
        prod_next    = prod_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        div_req.start    = 1'b0;
        div_req.dividend = a_mag[VAL_W-1:0];
        div_req.divisor  = s_mag[VAL_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (in_kind == KIND_QUERY))
                begin
                    q_next = in_q;
                    // clamp the point count into 2..TABLE_DEPTH
                    if (points_reg < CNT_W'(2))
                        last_next = IDX_W'(1);
                    else if (points_reg > CNT_W'(TABLE_DEPTH))
                        last_next = IDX_W'(TABLE_DEPTH - 1);
                    else
                        last_next = IDX_W'(points_reg - CNT_W'(1));
                    state_next = S_FIRST;
                end
            end
            S_FIRST:
                state_next = S_LAST;
            S_LAST:
            begin
                x_lo_next  = rd_x;
                y_lo_next  = rd_y;
                state_next = S_CLASS;
            end
            S_CLASS:
            begin
                x_hi_next = rd_x;
                y_hi_next = rd_y;
                if (q_reg < x_lo_reg)
                begin
                    status_next = STATUS_BELOW;
                    lo_next     = '0;
                    frac_next   = FRAC_ZERO;
                    interp_next = y_lo_reg;
                    state_next  = S_OUT;
                end
                else if (q_reg > rd_x)
                begin
                    status_next = STATUS_ABOVE;
                    lo_next     = last_reg - IDX_W'(1);
                    frac_next   = FRAC_ONE;
                    interp_next = rd_y;
                    state_next  = S_OUT;
                end
                else
                begin
                    status_next = STATUS_INSIDE;
                    lo_next     = '0;
                    hi_next     = last_reg;
                    state_next  = (last_reg > IDX_W'(1)) ? S_PROBE : S_FRAC;
                end
            end
            S_PROBE:
                state_next = S_CMP;
            S_CMP:
            begin
                if (q_reg > rd_x)
                begin
                    lo_next   = mid;
                    x_lo_next = rd_x;
                    y_lo_next = rd_y;
                end
                else
                begin
                    hi_next   = mid;
                    x_hi_next = rd_x;
                    y_hi_next = rd_y;
                end
                state_next = (gap_next > IDX_W'(1)) ? S_PROBE : S_FRAC;
            end
            S_FRAC:
            begin
                // zero span, zero offset or opposite signs all clamp to zero
                if (span == '0 || a_diff == '0 || (a_diff[VAL_W] != span[VAL_W]))
                begin
                    frac_next  = FRAC_ZERO;
                    state_next = S_MUL;
                end
                else if (a_mag >= s_mag)
                begin
                    frac_next  = FRAC_ONE;
                    state_next = S_MUL;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    frac_next  = {1'b0, div_rsp.quotient};
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = 51'($signed({1'b0, frac_reg})) * 51'(dy);
                state_next = S_ADD;
            end
            S_ADD:
            begin
                // floor of product / 2^16 is an arithmetic shift
                interp_next = y_lo_reg + prod_reg[47:16];
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {interp_reg, frac_reg, lo_reg, status_reg};
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            points_reg  <= CNT_W'(2);
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
                points_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg   <= last_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        q_reg      <= q_next;
        x_lo_reg   <= x_lo_next;
        x_hi_reg   <= x_hi_next;
        y_lo_reg   <= y_lo_next;
        y_hi_reg   <= y_hi_next;
        status_reg <= status_next;
        frac_reg   <= frac_next;
        interp_reg <= interp_next;
        prod_reg   <= prod_next;
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(64 - OUT_W)'(0), m_data_reg};

    property p_search_bracket;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (hi_reg > lo_reg) && (hi_reg - lo_reg > IDX_W'(1));
    endproperty
    a_search_bracket: assert property (p_search_bracket)
        else $error("search interval collapsed during probe");

    property p_div_done_in_wait;
        @(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV);
    endproperty
    a_div_done_in_wait: assert property (p_div_done_in_wait)
        else $error("divider finished outside the wait state");

    property p_frac_bound;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (frac_reg <= FRAC_ONE);
    endproperty
    a_frac_bound: assert property (p_frac_bound)
        else $error("fraction above one");

    property p_below_clamp;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && status_reg == STATUS_BELOW)
            |-> (lo_reg == '0) && (frac_reg == FRAC_ZERO);
    endproperty
    a_below_clamp: assert property (p_below_clamp)
        else $error("below-table result not clamped to the first point");

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_axis_tready) |=> (state_reg != S_IDLE || $stable(m_data_reg));
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("pending result overwritten");

endmodule

### tb/table_binary_search_linear_interp_test.sv
// Self-checking testbench for the table search and linear interpolation block.
module table_binary_search_linear_interp_test
    import tbsli_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint VAL_MIN_L   = -64'sd2147483648;
    localparam longint VAL_MAX_L   = 64'sd2147483647;
    localparam logic [31:0] VAL_MIN = 32'h8000_0000;
    localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam longint FRAC_UNIT   = longint'(FRAC_ONE);
    localparam int STALL_LIMIT     = 5000;
    localparam int SETTLE_CYCLES   = 50;
    localparam int HOLD_CYCLES     = 400;
    localparam int PHASES          = 11;
    localparam int QUERIES_PER_PHASE = 40;

    typedef enum int {LAYOUT_WIDE, LAYOUT_NARROW, LAYOUT_REPEAT, LAYOUT_SCRAMBLED,
                      LAYOUT_KEEP} layout_t;

    typedef struct packed {
        logic              kind;
        logic [31:0]       qx;
        logic [31:0]       ey;
        logic [31:0]       ex;
        logic [IDX_W-1:0]  idx;
    } table_req_t;

    // first member lands in the highest bits, so the order is reversed from the bus
    typedef struct packed {
        logic [31:0]            interp;
        logic [FRAC_FULL_W-1:0] frac;
        logic [IDX_W-1:0]       lower;
        logic [1:0]             status;
    } interp_res_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [8:0]   cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;   // entry_index, entry_x, entry_y, query_x
    logic         s_axis_tuser = 1'b0; // kind
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;        // status, lower_index, fraction, interpolated

    table_req_t  req_backlog[$];
    interp_res_t due_results[$];
    table_req_t  on_bus;
    interp_res_t want, got;

    longint      knot_x [TABLE_DEPTH];
    longint      knot_y [TABLE_DEPTH];
    logic [8:0]  points_cfg = 9'd2;

    longint      plan_x [TABLE_DEPTH];
    int unsigned plan_n = 2;

    bit          quiet = 1'b0;
    bit          hold_start = 1'b0;
    bit          hold_taken;
    int          hold_left;
    int          stall_cycles = 0;
    int          mismatches = 0;

    int unsigned phase_pts [PHASES] = '{256, 3, 0, 17, 511, 1, 100, 257, 4, 255, 2};
    layout_t     phase_layout [PHASES] = '{LAYOUT_WIDE, LAYOUT_NARROW, LAYOUT_REPEAT,
                                           LAYOUT_WIDE, LAYOUT_NARROW, LAYOUT_SCRAMBLED,
                                           LAYOUT_REPEAT, LAYOUT_KEEP, LAYOUT_WIDE,
                                           LAYOUT_KEEP, LAYOUT_NARROW};

    table_binary_search_linear_interp dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned active_count(input logic [8:0] v);
        if (v < 2)
            return 2;
        if (v > TABLE_DEPTH)
            return TABLE_DEPTH;
        return v;
    endfunction

    function automatic longint floor_quot(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b != 0) && ((a % b < 0) != (b < 0)))
            q = q - 1;
        return q;
    endfunction

    function automatic logic [31:0] random_y();
        case ($urandom_range(0, 9))
            0: return VAL_MIN;
            1: return VAL_MAX;
            default: return $urandom;
        endcase
    endfunction

    // Apply one accepted request to the table copy; queries queue their expected result.
    task automatic interp_lookup(input table_req_t r);
        int unsigned n, lo, hi, mid;
        longint q, frac, span, y0, y1;
        interp_res_t res;
        if (r.kind == KIND_WRITE)
        begin
            knot_x[r.idx] = $signed(r.ex);
            knot_y[r.idx] = $signed(r.ey);
        end
        else
        begin
            n = active_count(points_cfg);
            q = $signed(r.qx);
            if (q < knot_x[0])
            begin
                res.status = STATUS_BELOW;
                lo = 0;
                hi = 1;
                frac = 0;
            end
            else if (q > knot_x[n-1])
            begin
                res.status = STATUS_ABOVE;
                lo = n - 2;
                hi = n - 1;
                frac = FRAC_UNIT;
            end
            else
            begin
                res.status = STATUS_INSIDE;
                lo = 0;
                hi = n - 1;
                while (hi - lo > 1)
                begin
                    mid = (lo + hi) >> 1;
                    if (q > knot_x[mid])
                        lo = mid;
                    else
                        hi = mid;
                end
                span = knot_x[hi] - knot_x[lo];
                if (span == 0)
                    frac = 0;
                else
                begin
                    frac = floor_quot((q - knot_x[lo]) * FRAC_UNIT, span);
                    if (frac < 0)
                        frac = 0;
                    if (frac > FRAC_UNIT)
                        frac = FRAC_UNIT;
                end
            end
            y0 = knot_y[lo];
            y1 = knot_y[hi];
            y0 = y0 + floor_quot(frac * (y1 - y0), FRAC_UNIT);
            res.lower = lo[IDX_W-1:0];
            res.frac = frac[FRAC_FULL_W-1:0];
            res.interp = y0[31:0];
            due_results.push_back(res);
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    task automatic push_write(input logic [IDX_W-1:0] idx, input logic [31:0] xv,
                              input logic [31:0] yv);
        table_req_t r;
        r = '0;
        r.kind = KIND_WRITE;
        r.idx = idx;
        r.ex = xv;
        r.ey = yv;
        r.qx = $urandom;
        req_backlog.push_back(r);
        plan_x[idx] = longint'($signed(xv));
    endtask

    task automatic push_query(input logic [31:0] qv);
        table_req_t r;
        r.kind = KIND_QUERY;
        r.idx = IDX_W'($urandom);
        r.ex = $urandom;
        r.ey = $urandom;
        r.qx = qv;
        req_backlog.push_back(r);
    endtask

    // Fill entries 0..n-1; all layouts but the scrambled one rise monotonically.
    task automatic load_table(input int unsigned n, input layout_t layout);
        longint xv, step_max, step;
        int unsigned i;
        if (layout == LAYOUT_WIDE)
        begin
            step_max = 64'sd4294967295 / n;
            xv = VAL_MIN_L + $urandom_range(0, step_max);
        end
        else
        begin
            step_max = $urandom_range(1, 5000);
            xv = VAL_MIN_L + $urandom_range(0, 64'sd4294967295 - n * step_max);
        end
        for (i = 0; i < n; i++)
        begin
            if (layout == LAYOUT_SCRAMBLED)
                xv = $signed($urandom);
            push_write(i[IDX_W-1:0], xv[31:0], random_y());
            if (layout == LAYOUT_REPEAT && $urandom_range(0, 2) == 0)
                step = 0;
            else
                step = $urandom_range(0, step_max);
            xv = xv + step;
            if (xv > VAL_MAX_L)
                xv = VAL_MAX_L;
        end
    endtask

    task automatic push_random_query();
        int unsigned pick, i;
        longint a, b, q;
        pick = $urandom_range(0, 99);
        i = $urandom_range(0, plan_n - 2);
        a = plan_x[i];
        b = plan_x[i+1];
        if (a > b)
        begin
            q = a;
            a = b;
            b = q;
        end
        if (pick < 10)
            q = plan_x[0] - $urandom_range(1, 1000);
        else if (pick < 20)
            q = plan_x[plan_n-1] + $urandom_range(1, 1000);
        else if (pick < 35)
            q = plan_x[$urandom_range(0, plan_n - 1)];
        else if (pick < 90)
            q = a + longint'($urandom) % (b - a + 1);
        else
            q = $signed($urandom);
        if (q < VAL_MIN_L)
            q = VAL_MIN_L;
        if (q > VAL_MAX_L)
            q = VAL_MAX_L;
        push_query(q[31:0]);
    endtask

    // Block is idle once nothing is queued, offered or due, plus its longest busy time.
    task automatic wait_drain();
        while (req_backlog.size() != 0 || s_axis_tvalid || due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_points(input logic [8:0] v);
        wait_drain();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        points_cfg = v;
        plan_n = active_count(v);
    endtask

    // Request driver: hold a request until taken, idle at random between requests.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                interp_lookup(on_bus);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (req_backlog.size() != 0 && (quiet || $urandom_range(0, 99) >= 13))
                begin
                    on_bus = req_backlog.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {on_bus.qx, on_bus.ey, on_bus.ex, on_bus.idx};
                    s_axis_tuser <= on_bus.kind;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver backpressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= 0;
            hold_taken <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (due_results.size() == 0)
                begin
                    $display("%0t: result with nothing expected: expected none, got %h",
                             $time, m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    got = interp_res_t'(m_axis_tdata[58:0]);
                    compare_field("status", 32'(want.status), 32'(got.status));
                    compare_field("lower_index", 32'(want.lower), 32'(got.lower));
                    compare_field("fraction", 32'(want.frac), 32'(got.frac));
                    compare_field("interpolated", want.interp, got.interp);
                end
            end
            if (hold_start && !hold_taken)
            begin
                hold_taken <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= quiet || $urandom_range(0, 99) >= 13;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        int unsigned p, k;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // full-range table at the reset point count
        push_write(0, VAL_MIN, VAL_MIN);
        push_write(1, VAL_MAX, VAL_MAX);
        push_query(VAL_MIN);
        push_query(VAL_MAX);
        push_query(32'd0);
        push_query(32'hFFFF_FFFF);
        // unit span: below, inside, on the top point, above
        push_write(0, 32'd0, 32'h0064_0000);
        push_write(1, 32'h0001_0000, -32'sd5);
        push_query(VAL_MIN);
        push_query(32'hFFFF_FFFF);
        push_query(32'h0000_8000);
        push_query(32'h0001_0000);
        push_query(VAL_MAX);
        // equal x entries give a zero span
        push_write(1, 32'd0, 32'd7);
        push_query(32'd0);
        push_query(32'd1);
        push_query(32'hFFFF_FFFF);
        // falling y across the extremes
        push_write(0, -32'sd16, VAL_MAX);
        push_write(1, 32'sd16, VAL_MIN);
        push_query(32'd0);
        push_query(32'd15);

        for (p = 0; p < PHASES; p++)
        begin
            write_points(phase_pts[p][8:0]);
            quiet = (p == 3);
            if (phase_layout[p] != LAYOUT_KEEP)
                load_table(plan_n, phase_layout[p]);
            for (k = 0; k < QUERIES_PER_PHASE; k++)
            begin
                // stray writes break the ordering now and then
                if ($urandom_range(0, 19) == 0)
                    push_write(IDX_W'($urandom), $urandom, random_y());
                push_random_query();
            end
            if (p == 0)
            begin
                // stall the receiver once the queries are on their way
                while (req_backlog.size() > 45)
                    @(posedge clk);
                hold_start = 1'b1;
            end
        end
        quiet = 1'b0;

        wait_drain();
        if (mismatches == 0 && due_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
